### src/u2u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and codes for the UTF-8 to 16-bit code point decoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

	typedef enum logic [1:0] {
		ST_CHAR    = 2'd0,
		ST_END     = 2'd1,
		ST_INVALID = 2'd2,
		ST_TRUNC   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  pending;
		logic [15:0] partial;
	} dec_state_t;

	typedef struct packed {
		logic        emit;
		logic [15:0] code_point;
		status_t     status;
	} dec_result_t;

endpackage

### src/u2u_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_step
// Per-byte decode: next decoder state and the optional result for one byte.
// ----------------------------------------------------------------------------
module u2u_step (
	input  logic [7:0]          byte_val,
	input  u2u_pkg::dec_state_t cur,
	output u2u_pkg::dec_state_t nxt,
	output u2u_pkg::dec_result_t res
);

	logic [15:0] cont_bits;
	logic [15:0] merged;

	always_comb begin
		if (cur.pending[1]) begin
			cont_bits = {4'd0, byte_val[5:0], 6'd0};
		end else begin
			cont_bits = {10'd0, byte_val[5:0]};
		end
		merged = cur.partial | cont_bits;
	end

	always_comb begin
		nxt            = cur;
		res.emit       = 1'b0;
		res.code_point = 16'd0;
		res.status     = u2u_pkg::ST_CHAR;
		if (byte_val == 8'd0) begin
			nxt.pending = 2'd0;
			nxt.partial = 16'd0;
			res.emit    = 1'b1;
			res.status  = (cur.pending != 2'd0) ? u2u_pkg::ST_TRUNC : u2u_pkg::ST_END;
		end else if (cur.pending != 2'd0) begin
			nxt.pending = cur.pending - 2'd1;
			if (cur.pending == 2'd1) begin
				nxt.partial    = 16'd0;
				res.emit       = 1'b1;
				res.code_point = merged;
			end else begin
				nxt.partial = merged;
			end
		end else if (byte_val inside {[8'h01:8'h7f]}) begin
			res.emit       = 1'b1;
			res.code_point = {8'd0, byte_val};
		end else if (byte_val inside {[8'hc0:8'hdf]}) begin
			nxt.pending = 2'd1;
			nxt.partial = {5'd0, byte_val[4:0], 6'd0};
		end else if (byte_val inside {[8'he0:8'hef]}) begin
			nxt.pending = 2'd2;
			nxt.partial = {byte_val[3:0], 12'd0};
		end else begin
			res.emit   = 1'b1;
			res.status = u2u_pkg::ST_INVALID;
		end
	end

endmodule

### src/utf8_to_ucs2_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// UTF-8 byte stream to 16-bit (BMP) code points with end and error status.
// ----------------------------------------------------------------------------
// Input channel: byte_in with byte_valid/byte_stall, one byte per transfer.
// Output channel: code_point and status with cp_valid/cp_stall.
// A byte passes an input register, then the decode logic, then the result
// register: a byte that completes a character, ends the string or is in
// error shows on the output once the result register has taken it. Lead
// bytes and middle continuation bytes give no output transfer.
// Throughput is one byte per cycle while cp_stall is low; the result
// register and the input register each take a new value every cycle.
// When the receiver stalls, the result register holds and the input
// register fills; byte_stall then rises until the result is taken.
// Reset clears both valid flags and the decoder state (no sequence open).
// status: 0 character, 1 end of string, 2 invalid lead byte,
// 3 truncated sequence; code_point is zero for all but status 0.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  logic [7:0]           byte_in,
	output logic                 cp_valid,
	input  logic                 cp_stall,
	output logic [15:0]          code_point,
	output logic [1:0]           status
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	u2u_pkg::dec_state_t   state_q;
	u2u_pkg::dec_state_t   state_nxt;
	u2u_pkg::dec_result_t  res;
	logic                  out_free;
	logic                  go_s1;
	logic                  valid_s2;
	logic [15:0]           cp_s2;
	u2u_pkg::status_t      status_s2;

	assign out_free   = !valid_s2 || !cp_stall;
	assign go_s1      = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;

	u2u_step u_step (
		.byte_val (byte_s1),
		.cur      (state_q),
		.nxt      (state_nxt),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= byte_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (go_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= go_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && res.emit) begin
			cp_s2     <= res.code_point;
			status_s2 <= res.status;
		end
	end

	assign cp_valid   = valid_s2;
	assign code_point = cp_s2;
	assign status     = status_s2;

`ifndef NO_ASSERTIONS
	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pending != 2'd3)
		else $error("pending count out of range");

	a_err_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && status_s2 != u2u_pkg::ST_CHAR |-> cp_s2 == 16'd0)
		else $error("nonzero code point on end or error result");

	a_two_byte_lead: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && state_q.pending == 2'd0 && byte_s1[7:5] == 3'b110
		|=> state_q.pending == 2'd1)
		else $error("two-byte lead did not open a sequence");

	a_mid_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && state_q.pending == 2'd2 && byte_s1 != 8'd0 |-> !res.emit)
		else $error("result emitted in the middle of a sequence");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with no item held");
`endif

endmodule

### sim/tb_utf8_to_ucs2_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_ucs2_decoder
// Self-checking bench for the UTF-8 to 16-bit code point decoder. A short
// table of edge-case bytes is sent first, then about a thousand bytes of
// random text that is mostly well-formed, with stray, unsupported-lead,
// truncated and unchecked-continuation noise mixed in. Every accepted byte
// runs through a local decoder model; each output transfer is compared
// with the oldest predicted character. Bursty input, a varying output
// stall pattern and one long output hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_utf8_to_ucs2_decoder;

	typedef struct {
		logic [15:0]      cp;
		u2u_pkg::status_t st;
	} decoded_t;

	typedef struct {
		logic [7:0]       b;
		bit               typed;
		logic [15:0]      cp;
		u2u_pkg::status_t st;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_stall;
	logic [7:0]  byte_in;
	logic        cp_valid;
	logic        cp_stall;
	logic [15:0] code_point;
	logic [1:0]  status;

	decoded_t    decoded_q [$];
	int          mismatches;
	logic [1:0]  seq_left;
	logic [15:0] seq_bits;
	int          burst_left;
	bit          hold_go;
	bit          hold_done;

	dir_row_t dir_tbl [25] = '{
		'{8'h00, 1'b1, 16'h0000, u2u_pkg::ST_END},
		'{8'h01, 1'b1, 16'h0001, u2u_pkg::ST_CHAR},
		'{8'h7f, 1'b1, 16'h007f, u2u_pkg::ST_CHAR},
		'{8'h80, 1'b1, 16'h0000, u2u_pkg::ST_INVALID},
		'{8'hbf, 1'b1, 16'h0000, u2u_pkg::ST_INVALID},
		'{8'hf0, 1'b1, 16'h0000, u2u_pkg::ST_INVALID},
		'{8'hff, 1'b1, 16'h0000, u2u_pkg::ST_INVALID},
		'{8'hc0, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'h80, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'hdf, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'hbf, 1'b1, 16'h07ff, u2u_pkg::ST_CHAR},
		'{8'he0, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'h80, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'h80, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'hef, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'hbf, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'hbf, 1'b1, 16'hffff, u2u_pkg::ST_CHAR},
		'{8'hc3, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'h00, 1'b1, 16'h0000, u2u_pkg::ST_TRUNC},
		'{8'he2, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'h82, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'h00, 1'b1, 16'h0000, u2u_pkg::ST_TRUNC},
		'{8'he4, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'hff, 1'b0, 16'h0000, u2u_pkg::ST_CHAR},
		'{8'h41, 1'b0, 16'h0000, u2u_pkg::ST_CHAR}
	};

	utf8_to_ucs2_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_in    (byte_in),
		.cp_valid   (cp_valid),
		.cp_stall   (cp_stall),
		.code_point (code_point),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_600_000;
		$display("tb_utf8_to_ucs2_decoder: errors");
		$finish;
	end

	// decoder model: one byte in, at most one character out
	task automatic decode_byte(input logic [7:0] b, output bit has,
			output logic [15:0] cp, output u2u_pkg::status_t st);
		has = 1'b0;
		cp  = 16'h0000;
		st  = u2u_pkg::ST_CHAR;
		if (b == 8'h00) begin
			has      = 1'b1;
			st       = (seq_left != 2'd0) ? u2u_pkg::ST_TRUNC : u2u_pkg::ST_END;
			seq_left = 2'd0;
			seq_bits = 16'h0000;
		end else if (seq_left != 2'd0) begin
			if (seq_left == 2'd2)
				seq_bits = seq_bits | {4'h0, b[5:0], 6'h00};
			else
				seq_bits = seq_bits | {10'h000, b[5:0]};
			seq_left = seq_left - 2'd1;
			if (seq_left == 2'd0) begin
				has      = 1'b1;
				cp       = seq_bits;
				seq_bits = 16'h0000;
			end
		end else if (b[7] == 1'b0) begin
			has = 1'b1;
			cp  = {8'h00, b};
		end else if (b[7:5] == 3'b110) begin
			seq_bits = {5'h00, b[4:0], 6'h00};
			seq_left = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			seq_bits = {b[3:0], 12'h000};
			seq_left = 2'd2;
		end else begin
			has = 1'b1;
			st  = u2u_pkg::ST_INVALID;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input bit typed,
			input logic [15:0] tcp, input u2u_pkg::status_t tst);
		int               gap;
		bit               has;
		logic [15:0]      cp;
		u2u_pkg::status_t st;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				@(negedge clk);
				byte_valid <= 1'b0;
				byte_in    <= 8'($urandom_range(0, 255));
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left = burst_left - 1;
		@(negedge clk);
		byte_valid <= 1'b1;
		byte_in    <= b;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		decode_byte(b, has, cp, st);
		if (has) begin
			if (typed)
				decoded_q.push_back('{tcp, tst});
			else
				decoded_q.push_back('{cp, st});
		end
	endtask

	always @(posedge clk) begin
		decoded_t e;
		if (arst_n && cp_valid && !cp_stall) begin
			if (decoded_q.size() == 0) begin
				$display("%0t: transfer expected none actual cp=%h status=%0d",
					$realtime, code_point, status);
				mismatches++;
			end else begin
				e = decoded_q.pop_front();
				if (code_point !== e.cp) begin
					$display("%0t: code_point expected %h actual %h",
						$realtime, e.cp, code_point);
					mismatches++;
				end
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, e.st, status);
					mismatches++;
				end
			end
		end
	end

	// output side: stall pattern changes mode now and then; one long hold-off
	initial begin
		int mode;
		int len;
		cp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				for (int i = 0; i < 400; i++) begin
					@(negedge clk);
					cp_stall <= 1'b1;
				end
			end else begin
				mode = $urandom_range(0, 3);
				len  = $urandom_range(20, 200);
				for (int i = 0; i < len && !(hold_go && !hold_done); i++) begin
					@(negedge clk);
					case (mode)
						0: cp_stall <= 1'b0;
						1: cp_stall <= ($urandom_range(0, 3) == 0);
						2: cp_stall <= ($urandom_range(0, 3) != 0);
						default: cp_stall <= i[0];
					endcase
				end
			end
		end
	end

	initial begin
		logic [7:0] seq [$];
		int         sent;
		int         pick;
		arst_n     = 1'b0;
		byte_valid = 1'b0;
		byte_in    = 8'h00;
		mismatches = 0;
		seq_left   = 2'd0;
		seq_bits   = 16'h0000;
		burst_left = 0;
		hold_go    = 1'b0;
		hold_done  = 1'b0;
		sent       = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tbl[i])
			send_byte(dir_tbl[i].b, dir_tbl[i].typed, dir_tbl[i].cp, dir_tbl[i].st);

		while (sent < 1000) begin
			seq.delete();
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				seq.push_back(8'($urandom_range(8'h01, 8'h7f)));
			end else if (pick < 55) begin
				seq.push_back(8'($urandom_range(8'hc0, 8'hdf)));
				seq.push_back(8'($urandom_range(8'h80, 8'hbf)));
			end else if (pick < 80) begin
				seq.push_back(8'($urandom_range(8'he0, 8'hef)));
				seq.push_back(8'($urandom_range(8'h80, 8'hbf)));
				seq.push_back(8'($urandom_range(8'h80, 8'hbf)));
			end else if (pick < 85) begin
				seq.push_back(8'h00);
			end else if (pick < 88) begin
				seq.push_back(8'($urandom_range(8'h80, 8'hbf)));
			end else if (pick < 91) begin
				seq.push_back(8'($urandom_range(8'hf0, 8'hff)));
			end else if (pick < 94) begin
				// sequence cut short by end of string
				if ($urandom_range(0, 1)) begin
					seq.push_back(8'($urandom_range(8'hc0, 8'hdf)));
				end else begin
					seq.push_back(8'($urandom_range(8'he0, 8'hef)));
					if ($urandom_range(0, 1))
						seq.push_back(8'($urandom_range(8'h80, 8'hbf)));
				end
				seq.push_back(8'h00);
			end else if (pick < 97) begin
				// continuation with arbitrary top bits
				if ($urandom_range(0, 1)) begin
					seq.push_back(8'($urandom_range(8'hc0, 8'hdf)));
				end else begin
					seq.push_back(8'($urandom_range(8'he0, 8'hef)));
					seq.push_back(8'($urandom_range(8'h01, 8'hff)));
				end
				seq.push_back(8'($urandom_range(8'h01, 8'hff)));
			end else begin
				seq.push_back(8'($urandom_range(8'h00, 8'hff)));
			end
			foreach (seq[k]) begin
				send_byte(seq[k], 1'b0, 16'h0000, u2u_pkg::ST_CHAR);
				sent++;
				if (sent == 300)
					hold_go = 1'b1;
			end
		end
		send_byte(8'h00, 1'b0, 16'h0000, u2u_pkg::ST_CHAR);

		@(negedge clk);
		byte_valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_utf8_to_ucs2_decoder: clean");
		else
			$display("tb_utf8_to_ucs2_decoder: errors");
		$finish;
	end

endmodule
